// ----- src/sparse_row_bonus_accumulator_assert.svh -----
// Assertion macros shared by the checker of the sparse row bonus accumulator.
`ifndef SPARSE_ROW_BONUS_ACCUMULATOR_ASSERT_SVH
`define SPARSE_ROW_BONUS_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SRBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SRBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/srba_pkg.sv -----
// Types, constants and codes of the sparse row bonus accumulator.
package srba_pkg;

  localparam int SLOTS_PER_ROW_DEF = 16;
  localparam int MAX_ROWS_DEF      = 4096;
  localparam int MAX_COLS_DEF      = 4096;

  localparam int FUNC_W   = 2;
  localparam int POS_W    = 12;
  localparam int MASK_W   = 32;
  localparam int SIDX_W   = 4;
  localparam int STATUS_W = 2;
  localparam int RCOL_W   = 13;
  localparam int VAL_W    = 32;
  localparam int WEIGHT_W = 24;
  localparam int LIMIT_W  = 13;
  localparam int PCNT_W   = 6;
  localparam int INC_W    = WEIGHT_W + PCNT_W;

  localparam logic [RCOL_W-1:0] COL_NONE = '1;

  localparam logic [1:0] REG_WEIGHT    = 2'd0;
  localparam logic [1:0] REG_ROW_LIMIT = 2'd1;
  localparam logic [1:0] REG_COL_LIMIT = 2'd2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_ACC   = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_SAT   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_EXEC
  } state_e;

  typedef struct packed {
    func_e              func;
    logic [POS_W-1:0]   col;
    logic [SIDX_W-1:0]  sidx;
    logic               in_range;
    logic [INC_W-1:0]   inc;
  } item_t;

  typedef struct packed {
    logic               we;
    status_e            status;
    logic [RCOL_W-1:0]  read_col;
    logic [VAL_W-1:0]   read_value;
  } upd_t;

endpackage

// ----- src/srba_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
module srba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/srba_row_upd.sv -----
// Row word update: slot search, saturating accumulate and slot read.
module srba_row_upd #(
  parameter int SLOTS_PER_ROW = srba_pkg::SLOTS_PER_ROW_DEF,
  parameter int FILL_W        = $clog2(SLOTS_PER_ROW + 1),
  parameter int WORD_W        = FILL_W
                                + SLOTS_PER_ROW * (srba_pkg::POS_W + srba_pkg::VAL_W)
) (
  input  logic [WORD_W-1:0] row_word,
  input  srba_pkg::item_t   item,
  output logic [WORD_W-1:0] row_word_next,
  output srba_pkg::upd_t    upd
);

  localparam int SLOT_W  = srba_pkg::POS_W + srba_pkg::VAL_W;
  localparam int SLOT_IW = (SLOTS_PER_ROW > 1) ? $clog2(SLOTS_PER_ROW) : 1;

  logic [FILL_W-1:0]          fill;
  logic [srba_pkg::POS_W-1:0] col_a [SLOTS_PER_ROW];
  logic [srba_pkg::VAL_W-1:0] val_a [SLOTS_PER_ROW];
  logic [SLOTS_PER_ROW-1:0]   hit;
  logic                       found;
  logic                       full;
  logic [SLOT_IW-1:0]         hit_idx;
  logic [SLOT_IW-1:0]         tgt;
  logic [SLOT_IW-1:0]         rd_idx;
  logic [srba_pkg::VAL_W-1:0] old_val;
  logic [srba_pkg::VAL_W:0]   sum;
  logic                       sat;
  logic [srba_pkg::VAL_W-1:0] new_val;
  logic                       rd_hit;

  always_comb begin
    fill = row_word[FILL_W-1:0];
    for (int s = 0; s < SLOTS_PER_ROW; s++) begin
      col_a[s] = row_word[FILL_W + s*SLOT_W +: srba_pkg::POS_W];
      val_a[s] = row_word[FILL_W + s*SLOT_W + srba_pkg::POS_W +: srba_pkg::VAL_W];
      hit[s]   = (s < int'(fill)) && (col_a[s] == item.col);
    end
  end

  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int s = SLOTS_PER_ROW - 1; s >= 0; s--) begin
      if (hit[s]) begin
        found   = 1'b1;
        hit_idx = SLOT_IW'(s);
      end
    end
  end

  always_comb begin
    full    = (int'(fill) >= SLOTS_PER_ROW);
    tgt     = found ? hit_idx : SLOT_IW'(fill);
    old_val = found ? val_a[hit_idx] : '0;
    sum     = {1'b0, old_val} + (srba_pkg::VAL_W + 1)'(item.inc);
    sat     = sum[srba_pkg::VAL_W];
    new_val = sat ? '1 : sum[srba_pkg::VAL_W-1:0];
    rd_idx  = SLOT_IW'(item.sidx);
    rd_hit  = item.in_range && (int'(item.sidx) < int'(fill));
  end

  always_comb begin
    row_word_next = row_word;
    row_word_next[FILL_W-1:0] = found ? fill : FILL_W'(fill + 1'b1);
    for (int s = 0; s < SLOTS_PER_ROW; s++) begin
      if (SLOT_IW'(s) == tgt) begin
        row_word_next[FILL_W + s*SLOT_W +: SLOT_W] = {new_val, item.col};
      end
    end
  end

  always_comb begin
    upd.we         = 1'b0;
    upd.status     = srba_pkg::ST_DONE;
    upd.read_col   = srba_pkg::COL_NONE;
    upd.read_value = '0;
    unique case (item.func)
      srba_pkg::FUNC_ACC: begin
        if (!item.in_range) begin
          upd.status = srba_pkg::ST_RANGE;
        end else if (!found && full) begin
          upd.status = srba_pkg::ST_FULL;
        end else begin
          upd.we     = 1'b1;
          upd.status = sat ? srba_pkg::ST_SAT : srba_pkg::ST_DONE;
        end
      end
      srba_pkg::FUNC_READ: begin
        if (!item.in_range) begin
          upd.status = srba_pkg::ST_RANGE;
        end else if (rd_hit) begin
          upd.read_col   = {1'b0, col_a[rd_idx]};
          upd.read_value = val_a[rd_idx];
        end
      end
      srba_pkg::FUNC_CLEAR, srba_pkg::FUNC_NOP: begin
        upd.status = srba_pkg::ST_DONE;
      end
      default: begin
        upd.status = srba_pkg::ST_DONE;
      end
    endcase
  end

endmodule

// ----- src/sparse_row_bonus_accumulator.sv -----
// Top level of the sparse row bonus accumulator: control, registers and row memory.
//
// Items arrive on the s_ stream; func travels in s_tuser, the other fields in
// s_tdata. Every item gives exactly one result transfer on the m_ stream.
// The row memory holds one word per row: a fill count and all slots of the
// row, each slot a column and a Q16.16 value. An item reads its row word at
// its transfer; in S_EXEC, once the output register is free, it writes the
// updated word back and its result is registered. A new item is taken only in
// S_IDLE, after the last one has left S_EXEC, bound by the read-modify-write of
// the row memory. A clear item sweeps every row, one row a cycle, before its
// result in S_EXEC. After reset the same sweep runs with s_tready low; APB
// writes are taken throughout and never stall (pready high). A stalled m_ side
// holds its result in the output register; one further item is still taken and
// waits in S_EXEC, its row write held back, until that register is free.
// Registers: bonus_unit at 0x0, row_limit at 0x4, col_limit at 0x8; write
// them only while no item is in flight.
module sparse_row_bonus_accumulator #(
  parameter int SLOTS_PER_ROW = srba_pkg::SLOTS_PER_ROW_DEF,
  parameter int MAX_ROWS      = srba_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS      = srba_pkg::MAX_COLS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // row_pos[11:0], col_pos[23:12], support_mask[55:24], slot_index[59:56]
  input  logic [63:0] s_tdata,
  // func[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], read_col[14:2], read_value[46:15]
  output logic [47:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int FILL_W = $clog2(SLOTS_PER_ROW + 1);
  localparam int WORD_W = FILL_W + SLOTS_PER_ROW * (srba_pkg::POS_W + srba_pkg::VAL_W);
  localparam int ADDR_W = $clog2(MAX_ROWS);

  logic [srba_pkg::WEIGHT_W-1:0] bonus_unit;
  logic [srba_pkg::LIMIT_W-1:0]  row_limit;
  logic [srba_pkg::LIMIT_W-1:0]  col_limit;

  srba_pkg::state_e state, state_next;
  logic [ADDR_W-1:0] cnt, cnt_next;
  logic              cnt_last;
  srba_pkg::item_t   item, item_next;
  logic [ADDR_W-1:0] item_addr;

  logic                          accept;
  logic                          cfg_wr;
  logic                          out_free;
  logic [srba_pkg::POS_W-1:0]    in_row;
  logic [srba_pkg::POS_W-1:0]    in_col;
  logic [srba_pkg::MASK_W-1:0]   in_mask;
  logic [srba_pkg::SIDX_W-1:0]   in_sidx;
  srba_pkg::func_e               in_func;
  logic [2:0]                    nib [8];
  logic [srba_pkg::PCNT_W-1:0]   pcnt;
  logic                          row_ok;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] row_word_next;
  srba_pkg::upd_t    upd;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign accept   = s_tvalid & s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign cnt_last = (cnt == ADDR_W'(MAX_ROWS - 1));

  assign in_row  = s_tdata[11:0];
  assign in_col  = s_tdata[23:12];
  assign in_mask = s_tdata[55:24];
  assign in_sidx = s_tdata[59:56];
  assign in_func = srba_pkg::func_e'(s_tuser);

  always_comb begin
    pcnt = '0;
    for (int n = 0; n < 8; n++) begin
      nib[n] = 3'(in_mask[4*n]) + 3'(in_mask[4*n+1])
             + 3'(in_mask[4*n+2]) + 3'(in_mask[4*n+3]);
    end
    for (int n = 0; n < 8; n++) begin
      pcnt = pcnt + srba_pkg::PCNT_W'(nib[n]);
    end
  end

  always_comb begin
    row_ok = (srba_pkg::LIMIT_W'(in_row) < row_limit) && (int'(in_row) < MAX_ROWS);
    item_next.func = in_func;
    item_next.col  = in_col;
    item_next.sidx = in_sidx;
    item_next.inc  = srba_pkg::INC_W'(bonus_unit) * srba_pkg::INC_W'(pcnt);
    unique case (in_func)
      srba_pkg::FUNC_ACC: begin
        item_next.in_range = row_ok && (srba_pkg::LIMIT_W'(in_col) < col_limit)
                             && (int'(in_col) < MAX_COLS);
      end
      srba_pkg::FUNC_READ: begin
        item_next.in_range = row_ok && (int'(in_sidx) < SLOTS_PER_ROW);
      end
      srba_pkg::FUNC_CLEAR, srba_pkg::FUNC_NOP: begin
        item_next.in_range = 1'b0;
      end
      default: begin
        item_next.in_range = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      srba_pkg::S_INIT: begin
        if (cnt_last) begin
          state_next = srba_pkg::S_IDLE;
        end
      end
      srba_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (in_func == srba_pkg::FUNC_CLEAR) ? srba_pkg::S_CLEAR
                                                         : srba_pkg::S_EXEC;
        end
      end
      srba_pkg::S_CLEAR: begin
        if (cnt_last) begin
          state_next = srba_pkg::S_EXEC;
        end
      end
      srba_pkg::S_EXEC: begin
        if (out_free) begin
          state_next = srba_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = srba_pkg::S_INIT;
      end
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = item_addr;
    ram_wdata = row_word_next;
    cnt_next  = cnt;
    unique case (state)
      srba_pkg::S_INIT, srba_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = '0;
        cnt_next  = cnt_last ? '0 : cnt + 1'b1;
      end
      srba_pkg::S_IDLE: begin
        s_tready = 1'b1;
      end
      srba_pkg::S_EXEC: begin
        ram_we = out_free && upd.we;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  srba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (ADDR_W'(in_row)),
    .rdata (ram_rdata)
  );

  srba_row_upd #(
    .SLOTS_PER_ROW (SLOTS_PER_ROW),
    .FILL_W        (FILL_W),
    .WORD_W        (WORD_W)
  ) u_upd (
    .row_word      (ram_rdata),
    .item          (item),
    .row_word_next (row_word_next),
    .upd           (upd)
  );

  always_comb begin
    unique case (paddr[3:2])
      srba_pkg::REG_WEIGHT:    prdata = 32'(bonus_unit);
      srba_pkg::REG_ROW_LIMIT: prdata = 32'(row_limit);
      srba_pkg::REG_COL_LIMIT: prdata = 32'(col_limit);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bonus_unit <= '0;
      row_limit  <= '0;
      col_limit  <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        srba_pkg::REG_WEIGHT:    bonus_unit <= pwdata[srba_pkg::WEIGHT_W-1:0];
        srba_pkg::REG_ROW_LIMIT: row_limit  <= pwdata[srba_pkg::LIMIT_W-1:0];
        srba_pkg::REG_COL_LIMIT: col_limit  <= pwdata[srba_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= srba_pkg::S_INIT;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (state == srba_pkg::S_EXEC && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item      <= item_next;
      item_addr <= ADDR_W'(in_row);
    end
    if (state == srba_pkg::S_EXEC && out_free) begin
      m_tdata <= {1'b0, upd.read_value, upd.read_col, upd.status};
    end
  end

endmodule

// ----- src/srba_checker.sv -----
// Port-level checker of the sparse row bonus accumulator and its bind statement.
`include "sparse_row_bonus_accumulator_assert.svh"

module srba_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  `SRBA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
  `SRBA_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "input taken in consecutive cycles")
  `SRBA_ASSERT_NOW(a_empty_zero, m_tvalid && m_tdata[14:2] == srba_pkg::COL_NONE, m_tdata[46:15] == 32'd0, "empty slot read with a value")
  `SRBA_ASSERT_NOW(a_drop_no_col, m_tvalid && (m_tdata[1:0] == srba_pkg::ST_FULL || m_tdata[1:0] == srba_pkg::ST_SAT), m_tdata[14:2] == srba_pkg::COL_NONE, "accumulate result carries a column")
  `SRBA_ASSERT_NOW(a_reset_quiet, $past(rst), !m_tvalid && !s_tready, "activity straight after reset")

endmodule

bind sparse_row_bonus_accumulator srba_checker u_srba_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench of the sparse row bonus accumulator: directed table, then random phases.
`timescale 1ns / 100ps

module tb_top;
  import srba_pkg::*;

  localparam int QUIET_LIMIT = 20000;

  typedef struct packed {
    status_e           status;
    logic [RCOL_W-1:0] rcol;
    logic [VAL_W-1:0]  rval;
  } bonus_res_t;

  typedef struct packed {
    bit                is_cfg;
    logic [3:0]        addr;
    logic [31:0]       wdata;
    func_e             f;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [MASK_W-1:0] mask;
    logic [SIDX_W-1:0] sidx;
    int                reps;
    bit                typed;
    bonus_res_t        want;
  } step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Own copy of the bonus store and the register settings.
  logic [POS_W-1:0] slot_col_m [0:MAX_ROWS_DEF*SLOTS_PER_ROW_DEF-1];
  logic [VAL_W-1:0] slot_val_m [0:MAX_ROWS_DEF*SLOTS_PER_ROW_DEF-1];
  int               row_used [0:MAX_ROWS_DEF-1];
  bit [MAX_ROWS_DEF-1:0] row_live = '0;
  logic [WEIGHT_W-1:0]   weight_cfg = '0;
  int                    row_lim_cfg = 0;
  int                    col_lim_cfg = 0;

  bonus_res_t pending_results [$];
  bonus_res_t oldest;
  step_t      plan [$];
  int         fail_count = 0;
  int         items_sent = 0;
  int         clears_sent = 0;
  int         status_seen [4] = '{0, 0, 0, 0};
  int         send_idle_pct = 29;
  int         recv_idle_pct = 58;
  int         quiet_cycles = 0;

  sparse_row_bonus_accumulator u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bonus_res_t predict_bonus(input func_e f, input logic [63:0] d);
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [MASK_W-1:0] mask;
    logic [SIDX_W-1:0] sidx;
    int                used;
    int                base;
    int                slot;
    bit                hit;
    longint unsigned   sum;
    bonus_res_t        r;
    row  = d[11:0];
    col  = d[23:12];
    mask = d[55:24];
    sidx = d[59:56];
    r.status = ST_DONE;
    r.rcol   = COL_NONE;
    r.rval   = '0;
    base = int'(row) * SLOTS_PER_ROW_DEF;
    used = row_live[row] ? row_used[row] : 0;
    hit  = 1'b0;
    slot = 0;
    case (f)
      FUNC_CLEAR: row_live = '0;
      FUNC_ACC: begin
        if (row >= row_lim_cfg || col >= col_lim_cfg) begin
          r.status = ST_RANGE;
        end else begin
          for (int s = 0; s < used && !hit; s++) begin
            if (slot_col_m[base + s] == col) begin
              hit  = 1'b1;
              slot = s;
            end
          end
          if (!hit && used >= SLOTS_PER_ROW_DEF) begin
            r.status = ST_FULL;
          end else begin
            if (!hit) begin
              slot = used;
              slot_val_m[base + slot] = '0;
              row_used[row] = used + 1;
              row_live[row] = 1'b1;
            end
            slot_col_m[base + slot] = col;
            sum = 64'(slot_val_m[base + slot]) + 64'(weight_cfg) * 64'($countones(mask));
            if (sum > 64'hFFFF_FFFF) begin
              slot_val_m[base + slot] = '1;
              r.status = ST_SAT;
            end else begin
              slot_val_m[base + slot] = sum[31:0];
            end
          end
        end
      end
      FUNC_READ: begin
        if (row >= row_lim_cfg) begin
          r.status = ST_RANGE;
        end else if (sidx < used) begin
          r.rcol = {1'b0, slot_col_m[base + sidx]};
          r.rval = slot_val_m[base + sidx];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic step_t op_row(input func_e f, input int row, input int col,
                                   input logic [31:0] mask, input int sidx, input int reps,
                                   input bit typed, input status_e st,
                                   input logic [RCOL_W-1:0] rcol, input logic [31:0] rval);
    step_t t;
    t = '0;
    t.f = f;
    t.row = POS_W'(row);
    t.col = POS_W'(col);
    t.mask = mask;
    t.sidx = SIDX_W'(sidx);
    t.reps = reps;
    t.typed = typed;
    t.want.status = st;
    t.want.rcol = rcol;
    t.want.rval = rval;
    return t;
  endfunction

  function automatic step_t reg_row(input logic [1:0] idx, input logic [31:0] data);
    step_t t;
    t = '0;
    t.is_cfg = 1'b1;
    t.addr = {idx, 2'b00};
    t.wdata = data;
    return t;
  endfunction

  task automatic push_item(input func_e f, input logic [63:0] d, input bit typed,
                           input bonus_res_t given);
    bonus_res_t calc;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    calc = predict_bonus(f, d);
    pending_results.push_back(typed ? given : calc);
    items_sent++;
    if (f == FUNC_CLEAR) clears_sent++;
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [31:0] data);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr[3:2])
      REG_WEIGHT:    weight_cfg = data[WEIGHT_W-1:0];
      REG_ROW_LIMIT: row_lim_cfg = data[LIMIT_W-1:0];
      REG_COL_LIMIT: col_lim_cfg = data[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // Receiver stalls, result checking and the watchdog.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    if (!rst && m_tvalid && m_tready) begin
      status_seen[m_tdata[1:0]]++;
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: %h", m_tdata);
        fail_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (m_tdata[1:0] !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, m_tdata[1:0]);
          fail_count++;
        end
        if (m_tdata[14:2] !== oldest.rcol) begin
          $error("read_col: expected %0d, got %0d", $signed(oldest.rcol),
                 $signed(m_tdata[14:2]));
          fail_count++;
        end
        if (m_tdata[46:15] !== oldest.rval) begin
          $error("read_value: expected %h, got %h", oldest.rval, m_tdata[46:15]);
          fail_count++;
        end
      end
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("sparse_row_bonus_accumulator: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    bonus_res_t        given;
    func_e             f;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [MASK_W-1:0] mask;
    logic [WEIGHT_W-1:0] w;
    int                rl;
    int                cl;
    int                span;
    int                pick;
    int                ph;

    // Limits are zero after reset, so the first accumulate and read items fall out of range.
    plan.push_back(op_row(FUNC_ACC,   0, 0, '1, 0, 1, 1, ST_RANGE, COL_NONE, '0));
    plan.push_back(op_row(FUNC_READ,  0, 0, '0, 0, 1, 1, ST_RANGE, COL_NONE, '0));
    plan.push_back(op_row(FUNC_NOP,   0, 0, '0, 0, 1, 1, ST_DONE,  COL_NONE, '0));
    plan.push_back(op_row(FUNC_CLEAR, 0, 0, '0, 0, 1, 1, ST_DONE,  COL_NONE, '0));
    plan.push_back(reg_row(REG_WEIGHT, 32'h00FF_FFFF));
    plan.push_back(reg_row(REG_ROW_LIMIT, 32'd4096));
    plan.push_back(reg_row(REG_COL_LIMIT, 32'd4096));
    // Eight full-weight transfers reach just under the top; the ninth saturates.
    plan.push_back(op_row(FUNC_ACC, 4095, 4095, '1, 0, 8, 0, ST_DONE, COL_NONE, '0));
    plan.push_back(op_row(FUNC_ACC, 4095, 4095, '1, 0, 1, 1, ST_SAT, COL_NONE, '0));
    plan.push_back(op_row(FUNC_READ, 4095, 0, '0, 0, 1, 1, ST_DONE, 13'd4095, '1));
    plan.push_back(op_row(FUNC_ACC, 4095, 0, '0, 0, 1, 1, ST_DONE, COL_NONE, '0));
    plan.push_back(op_row(FUNC_READ, 4095, 0, '0, 1, 1, 1, ST_DONE, 13'd0, '0));
    plan.push_back(op_row(FUNC_READ, 4095, 0, '0, 15, 1, 1, ST_DONE, COL_NONE, '0));
    plan.push_back(op_row(FUNC_ACC, 2048, 2730, 32'h8000_0001, 0, 1, 0, ST_DONE, COL_NONE, '0));
    plan.push_back(op_row(FUNC_READ, 2048, 0, '0, 0, 1, 0, ST_DONE, COL_NONE, '0));
    plan.push_back(reg_row(REG_WEIGHT, 32'd1));
    plan.push_back(reg_row(REG_ROW_LIMIT, 32'd16));
    plan.push_back(reg_row(REG_COL_LIMIT, 32'd16));
    plan.push_back(op_row(FUNC_ACC, 16, 0, '1, 0, 1, 1, ST_RANGE, COL_NONE, '0));
    plan.push_back(op_row(FUNC_ACC, 0, 16, '1, 0, 1, 1, ST_RANGE, COL_NONE, '0));
    plan.push_back(op_row(FUNC_READ, 16, 0, '0, 0, 1, 1, ST_RANGE, COL_NONE, '0));
    plan.push_back(op_row(FUNC_ACC, 15, 15, 32'h0000_FFFF, 0, 1, 1, ST_DONE, COL_NONE, '0));
    plan.push_back(op_row(FUNC_CLEAR, 0, 0, '0, 0, 1, 1, ST_DONE, COL_NONE, '0));
    plan.push_back(op_row(FUNC_READ, 15, 0, '0, 0, 1, 1, ST_DONE, COL_NONE, '0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].addr, plan[i].wdata);
      end else begin
        given = plan[i].want;
        repeat (plan[i].reps)
          push_item(plan[i].f, {4'b0, plan[i].sidx, plan[i].mask, plan[i].col, plan[i].row},
                    plan[i].typed, given);
      end
    end

    for (ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 29 : (ph < 4) ? 58 : 0;
      recv_idle_pct = (ph < 2) ? 58 : (ph < 4) ? 29 : 0;
      case (ph)
        0: begin w = WEIGHT_W'($urandom_range(1, 24'h00FFFF)); rl = 4; cl = 40; end
        1: begin w = 24'hFF_FFFF;                   rl = 2;    cl = 8;    end
        2: begin w = '0;                            rl = 4096; cl = 4096; end
        3: begin
          w  = WEIGHT_W'($urandom);
          rl = int'($urandom_range(1, 4096));
          cl = int'($urandom_range(1, 4096));
        end
        4: begin w = 24'd1;                         rl = 1;    cl = 4096; end
        default: begin w = WEIGHT_W'($urandom);     rl = 0;    cl = 0;    end
      endcase
      write_reg({REG_WEIGHT, 2'b00}, 32'(w));
      write_reg({REG_ROW_LIMIT, 2'b00}, 32'(rl));
      write_reg({REG_COL_LIMIT, 2'b00}, 32'(cl));
      repeat ((ph == 5) ? 100 : 370) begin
        pick = $urandom_range(0, 99);
        f = (pick < 2) ? FUNC_CLEAR : (pick < 5) ? FUNC_NOP : (pick < 60) ? FUNC_ACC : FUNC_READ;
        // Most rows and columns are taken near the edges of the valid range,
        // so that rows fill up and slots are hit again.
        span = (rl > 6) ? 6 : rl;
        if (rl == 0 || $urandom_range(0, 99) < 15) row = POS_W'($urandom);
        else if ($urandom_range(0, 1)) row = POS_W'($urandom_range(0, span - 1));
        else row = POS_W'(rl - 1 - int'($urandom_range(0, span - 1)));
        span = (cl > 24) ? 24 : cl;
        if (cl == 0 || $urandom_range(0, 99) < 15) col = POS_W'($urandom);
        else if ($urandom_range(0, 1)) col = POS_W'($urandom_range(0, span - 1));
        else col = POS_W'(cl - 1 - int'($urandom_range(0, span - 1)));
        case ($urandom_range(0, 4))
          0: mask = $urandom;
          1: mask = '1;
          2: mask = 32'd1 << $urandom_range(0, 31);
          3: mask = $urandom & $urandom;
          default: mask = '0;
        endcase
        given = '0;
        push_item(f, {4'b0, 4'($urandom_range(0, 15)), mask, col, row}, 1'b0, given);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d items (%0d clears) under eight programmed register settings and %s",
             items_sent, clears_sent, "three idling modes.");
    $display("Results seen: %0d done, %0d out of range, %0d row full, %0d saturated.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (fail_count == 0) begin
      $display("sparse_row_bonus_accumulator: match");
    end else begin
      $display("sparse_row_bonus_accumulator: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/srba_pkg.sv
src/srba_ram.sv
src/srba_row_upd.sv
src/sparse_row_bonus_accumulator.sv
src/srba_checker.sv
tb/sv/tb_top.sv
